[design/tcsg_pkg.sv]
// Shared types, register map and level table of the three-channel sound generator.
`timescale 1ns / 1ps

package tcsg_pkg;

    // Number of output channel slots, and how many of them carry a generator.
    localparam int MAX_CH   = 3;
    localparam int CHANNELS = 3;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef logic [3:0]  t_reg_idx;
    typedef logic [16:0] t_level;

    localparam t_reg_idx REG_TONE_BASE  = 4'd0;
    localparam t_reg_idx REG_NOISE      = 4'd6;
    localparam t_reg_idx REG_MIXER      = 4'd7;
    localparam t_reg_idx REG_AMP_BASE   = 4'd8;
    localparam t_reg_idx REG_ENV_FINE   = 4'd11;
    localparam t_reg_idx REG_ENV_COARSE = 4'd12;
    localparam t_reg_idx REG_ENV_SHAPE  = 4'd13;

    localparam logic [7:0] RD_DISABLED = 8'hFF;

    typedef struct packed {
        logic att;
        logic alt;
        logic hold;
    } t_env_flags;

    // One bus beat as seen by the register file.
    typedef struct packed {
        logic       write;
        logic       addr_select;
        logic [7:0] data;
    } t_bus_req;

    // Envelope restart on a shape write.
    typedef struct packed {
        logic       load;
        t_env_flags flags;
    } t_env_load;

    // Generator settings decoded from the register file.
    typedef struct packed {
        logic [MAX_CH-1:0][11:0] tone_period;
        logic [4:0]              noise_period_half;
        logic [5:0]              mixer;
        logic [MAX_CH-1:0][4:0]  amp;
        logic [15:0]             env_period_half;
    } t_gen_cfg;

    // Logarithmic volume table, Q16.
    function automatic t_level level_of(input logic [3:0] vol);
        t_level lvl;
        case (vol)
            4'd0:    lvl = 17'd0;
            4'd1:    lvl = 17'd898;
            4'd2:    lvl = 17'd1343;
            4'd3:    lvl = 17'd1907;
            4'd4:    lvl = 17'd2779;
            4'd5:    lvl = 17'd4050;
            4'd6:    lvl = 17'd5551;
            4'd7:    lvl = 17'd8972;
            4'd8:    lvl = 17'd11082;
            4'd9:    lvl = 17'd17347;
            4'd10:   lvl = 17'd23115;
            4'd11:   lvl = 17'd29485;
            4'd12:   lvl = 17'd37382;
            4'd13:   lvl = 17'd44807;
            4'd14:   lvl = 17'd55588;
            default: lvl = 17'd65536;
        endcase
        return lvl;
    endfunction

endpackage

[design/tcsg_ifs.sv]
// Valid/ready channel interfaces for the sound generator request and result beats.
`timescale 1ns / 1ps

interface tcsg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic       addr_select;
    logic [7:0] write_data;

    modport source(output valid, output op, output addr_select, output write_data,
                   input ready);
    modport sink(input valid, input op, input addr_select, input write_data,
                 output ready);
endinterface

interface tcsg_out_if;
    logic             valid;
    logic             ready;
    logic [7:0]       read_data;
    tcsg_pkg::t_level level_a;
    tcsg_pkg::t_level level_b;
    tcsg_pkg::t_level level_c;

    modport source(output valid, output read_data, output level_a, output level_b,
                   output level_c, input ready);
    modport sink(input valid, input read_data, input level_a, input level_b,
                 input level_c, output ready);
endinterface

[design/three_channel_sound_generator.sv]
// Top level of the three-channel sound generator: bus access, tick and result beat.
// The result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one beat per cycle; the state and result registers update in one pass.
// A new beat is taken whenever the result register is empty or drained that cycle.
// Reset (synchronous, active low): registers, dividers and envelope clear, noise
// shift register loads 1, the unit is enabled, and no result is pending.
`timescale 1ns / 1ps

module three_channel_sound_generator (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    tcsg_in_if.sink    i_in,
    tcsg_out_if.source o_out
);

    logic                 r_enabled;
    logic                 r_valid, n_valid;
    logic [7:0]           r_read_data;
    logic                 accept;
    logic [7:0]           rd_byte;
    tcsg_pkg::t_bus_req   bus_req;
    tcsg_pkg::t_gen_cfg   gen_cfg;
    tcsg_pkg::t_env_load  env_load;
    tcsg_pkg::t_level     level [tcsg_pkg::MAX_CH];

    // Take a beat when the result slot is free or being drained this cycle.
    assign i_in.ready = i_rst_n && (!r_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    // Enable bit: the user must write it only while the unit is idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
        end else if (i_cfg_we) begin
            r_enabled <= i_cfg_wdata;
        end
    end

    // Bus writes are dropped while disabled; ticks always run.
    always_comb begin
        bus_req.write       = accept && (i_in.op == tcsg_pkg::OP_WRITE) && r_enabled;
        bus_req.addr_select = i_in.addr_select;
        bus_req.data        = i_in.write_data;
    end

    tcsg_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (bus_req),
        .o_rd_byte  (rd_byte),
        .o_cfg      (gen_cfg),
        .o_env_load (env_load)
    );

    tcsg_gen u_gen (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (accept && (i_in.op == tcsg_pkg::OP_TICK)),
        .i_cfg      (gen_cfg),
        .i_env_load (env_load),
        .o_level    (level)
    );

    // Result valid: set by an accepted beat, hold until the sink takes it.
    assign n_valid = accept || (r_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Read byte: latch or register, 255 while disabled, zero for every other beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_in.op != tcsg_pkg::OP_READ) begin
                r_read_data <= 8'd0;
            end else if (!r_enabled) begin
                r_read_data <= tcsg_pkg::RD_DISABLED;
            end else begin
                r_read_data <= rd_byte;
            end
        end
    end

    // The channel level registers change only with an accepted tick, at the same
    // edge as the result register, so they serve as the level payload directly.
    assign o_out.valid     = r_valid;
    assign o_out.read_data = r_read_data;
    assign o_out.level_a   = level[0];
    assign o_out.level_b   = level[1];
    assign o_out.level_c   = level[2];

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted beat produced no result");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in.op != tcsg_pkg::OP_READ) |=> o_out.read_data == 8'd0)
        else $error("non-read beat returned nonzero read data");

    a_disabled_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in.op == tcsg_pkg::OP_READ) && !r_enabled
        |=> o_out.read_data == tcsg_pkg::RD_DISABLED)
        else $error("read while disabled did not return 255");

    a_levels_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in.op != tcsg_pkg::OP_TICK)
        |=> (o_out.level_a == $past(o_out.level_a)) &&
            (o_out.level_b == $past(o_out.level_b)) &&
            (o_out.level_c == $past(o_out.level_c)))
        else $error("channel levels moved without a tick");
`endif

endmodule

[design/tcsg_regs.sv]
// Register file, register-number latch and setting decode of the sound generator.
`timescale 1ns / 1ps

module tcsg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcsg_pkg::t_bus_req  i_req,
    output logic [7:0]          o_rd_byte,
    output tcsg_pkg::t_gen_cfg  o_cfg,
    output tcsg_pkg::t_env_load o_env_load
);

    logic [7:0] r_regs [16];
    logic [3:0] r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '{default: 8'd0};
            r_sel  <= 4'd0;
        end else if (i_req.write) begin
            if (i_req.addr_select) begin
                r_sel <= i_req.data[3:0];
            end else begin
                r_regs[r_sel] <= i_req.data;
            end
        end
    end

    assign o_rd_byte = i_req.addr_select ? {4'd0, r_sel} : r_regs[r_sel];

    // A shape write without the continue bit ends in a hold at zero.
    always_comb begin
        o_env_load.load       = i_req.write && !i_req.addr_select &&
                                (r_sel == tcsg_pkg::REG_ENV_SHAPE);
        o_env_load.flags.att  = i_req.data[2];
        o_env_load.flags.alt  = i_req.data[3] ? i_req.data[1] : i_req.data[2];
        o_env_load.flags.hold = i_req.data[0] | ~i_req.data[3];
    end

    always_comb begin
        for (int i = 0; i < tcsg_pkg::MAX_CH; i++) begin
            o_cfg.tone_period[i] = {
                r_regs[4'(tcsg_pkg::REG_TONE_BASE + 2 * i + 1)][3:0],
                r_regs[4'(tcsg_pkg::REG_TONE_BASE + 2 * i)]
            };
            o_cfg.amp[i] = r_regs[4'(tcsg_pkg::REG_AMP_BASE + i)][4:0];
        end
        o_cfg.noise_period_half = r_regs[tcsg_pkg::REG_NOISE][4:0];
        o_cfg.mixer             = r_regs[tcsg_pkg::REG_MIXER][5:0];
        o_cfg.env_period_half   = {r_regs[tcsg_pkg::REG_ENV_COARSE],
                                   r_regs[tcsg_pkg::REG_ENV_FINE]};
    end

endmodule

[design/tcsg_gen.sv]
// Tone dividers, noise shift register, envelope and channel level lookup.
`timescale 1ns / 1ps

module tcsg_gen (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  tcsg_pkg::t_gen_cfg  i_cfg,
    input  tcsg_pkg::t_env_load i_env_load,
    output tcsg_pkg::t_level    o_level [tcsg_pkg::MAX_CH]
);

    logic [11:0]           r_tone_count [tcsg_pkg::MAX_CH];
    logic [11:0]           n_tone_count [tcsg_pkg::MAX_CH];
    logic                  r_tone_phase [tcsg_pkg::MAX_CH];
    logic                  n_tone_phase [tcsg_pkg::MAX_CH];
    tcsg_pkg::t_level      r_level      [tcsg_pkg::MAX_CH];
    tcsg_pkg::t_level      n_level      [tcsg_pkg::MAX_CH];
    logic [5:0]            r_noise_count, n_noise_count;
    logic [16:0]           r_noise_shift, n_noise_shift;
    logic                  r_noise_bit,   n_noise_bit;
    logic [16:0]           r_env_count,   n_env_count;
    logic [4:0]            r_env_idx,     n_env_idx;
    logic [3:0]            r_env_level,   n_env_level;
    tcsg_pkg::t_env_flags  r_env_flags,   n_env_flags;

    logic                  env_att;
    logic [3:0]            ch_vol [tcsg_pkg::MAX_CH];
    logic                  ch_on  [tcsg_pkg::MAX_CH];

    always_comb begin
        n_noise_count = r_noise_count;
        n_noise_shift = r_noise_shift;
        n_noise_bit   = r_noise_bit;
        n_env_count   = r_env_count;
        n_env_idx     = r_env_idx;
        n_env_level   = r_env_level;
        n_env_flags   = r_env_flags;
        env_att       = r_env_flags.att;
        for (int i = 0; i < tcsg_pkg::MAX_CH; i++) begin
            n_tone_count[i] = r_tone_count[i];
            n_tone_phase[i] = r_tone_phase[i];
            n_level[i]      = r_level[i];
            ch_vol[i]       = 4'd0;
            ch_on[i]        = 1'b0;
        end

        if (i_env_load.load) begin
            n_env_flags = i_env_load.flags;
            n_env_idx   = 5'd0;
        end

        if (i_tick) begin
            // Noise: shift right, feedback from bits 0 and 2.
            n_noise_count = r_noise_count + 6'd1;
            if (n_noise_count >= {i_cfg.noise_period_half, 1'b0}) begin
                n_noise_count = 6'd0;
                n_noise_shift = {r_noise_shift[0] ^ r_noise_shift[2], r_noise_shift[16:1]};
                n_noise_bit   = n_noise_shift[1];
            end

            // Envelope: step once per period, holding or repeating after 16 steps.
            n_env_count = r_env_count + 17'd1;
            if (n_env_count >= {i_cfg.env_period_half, 1'b0}) begin
                n_env_count = 17'd0;
                if ((r_env_idx >= 5'd16) && r_env_flags.hold) begin
                    n_env_level = (r_env_flags.alt ? env_att : !env_att) ? 4'd0 : 4'd15;
                end else begin
                    if (r_env_idx >= 5'd16) begin
                        n_env_idx = 5'd0;
                        if (r_env_flags.alt) begin
                            n_env_flags.att = ~r_env_flags.att;
                            env_att         = ~r_env_flags.att;
                        end
                    end
                    n_env_level = env_att ? n_env_idx[3:0] : (4'd15 - n_env_idx[3:0]);
                    n_env_idx   = n_env_idx + 5'd1;
                end
            end

            for (int i = 0; i < tcsg_pkg::MAX_CH; i++) begin
                if (i < tcsg_pkg::CHANNELS) begin
                    n_tone_count[i] = r_tone_count[i] + 12'd1;
                    if (n_tone_count[i] >= i_cfg.tone_period[i]) begin
                        n_tone_count[i] = 12'd0;
                        n_tone_phase[i] = ~r_tone_phase[i];
                    end
                    ch_on[i]   = (i_cfg.mixer[i] | n_tone_phase[i]) &
                                 (i_cfg.mixer[i + 3] | n_noise_bit);
                    ch_vol[i]  = i_cfg.amp[i][4] ? n_env_level : i_cfg.amp[i][3:0];
                    n_level[i] = ch_on[i] ? tcsg_pkg::level_of(ch_vol[i]) : 17'd0;
                end else begin
                    n_level[i] = 17'd0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tcsg_pkg::MAX_CH; i++) begin
                r_tone_count[i] <= 12'd0;
                r_tone_phase[i] <= 1'b0;
                r_level[i]      <= 17'd0;
            end
            r_noise_count <= 6'd0;
            r_noise_shift <= 17'd1;
            r_noise_bit   <= 1'b0;
            r_env_count   <= 17'd0;
            r_env_idx     <= 5'd0;
            r_env_level   <= 4'd0;
            r_env_flags   <= '0;
        end else begin
            for (int i = 0; i < tcsg_pkg::MAX_CH; i++) begin
                r_tone_count[i] <= n_tone_count[i];
                r_tone_phase[i] <= n_tone_phase[i];
                r_level[i]      <= n_level[i];
            end
            r_noise_count <= n_noise_count;
            r_noise_shift <= n_noise_shift;
            r_noise_bit   <= n_noise_bit;
            r_env_count   <= n_env_count;
            r_env_idx     <= n_env_idx;
            r_env_level   <= n_env_level;
            r_env_flags   <= n_env_flags;
        end
    end

    assign o_level = r_level;

endmodule
